[rtl/core/exact_drift_particle_map_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the exact drift particle map
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef EXACT_DRIFT_PARTICLE_MAP_ASSERT_SVH
`define EXACT_DRIFT_PARTICLE_MAP_ASSERT_SVH

// same-cycle implication
`define EDPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edpm: implication check failed");

// next-cycle implication
`define EDPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edpm: next-cycle check failed");

`endif

[rtl/core/edpm_pkg.sv]
// ---------------------------------------------------------------------------
// edpm_pkg
// Formats, widths and payload types of the exact drift particle map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package edpm_pkg;

	// fixed-point format (FRAC_BITS at most WORD_BITS-2)
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 24;

	// derived widths
	localparam int QW  = WORD_BITS + FRAC_BITS;         // pz at scale S^2
	localparam int SW  = QW + 1;                        // pz + (1+delta)
	localparam int DW  = QW + SW;                       // z denominator
	localparam int NXW = 2 * WORD_BITS + FRAC_BITS;     // x/y numerator
	localparam int NZW = 3 * WORD_BITS + 2 * FRAC_BITS; // z numerator
	localparam int QLO = QW / 2;
	localparam int QHI = QW - QLO;
	localparam int SLO = SW / 2;
	localparam int SHI = SW - SLO;

	// one in fixed point
	localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] x_pos;
		logic signed [WORD_BITS-1:0] y_pos;
		logic signed [WORD_BITS-1:0] z_pos;
		logic signed [WORD_BITS-1:0] px_mom;
		logic signed [WORD_BITS-1:0] py_mom;
		logic signed [WORD_BITS-1:0] delta_mom;
		logic                        last_in;
	} in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] x_new;
		logic signed [WORD_BITS-1:0] y_new;
		logic signed [WORD_BITS-1:0] z_new;
		logic signed [WORD_BITS-1:0] px_out;
		logic signed [WORD_BITS-1:0] py_out;
		logic signed [WORD_BITS-1:0] delta_out;
		logic                        invalid;
		logic                        last_out;
	} out_t;

	// item copy plus drift sign and nonphysical flag
	typedef struct packed {
		in_t  item;
		logic ln;
		logic bad;
	} pass_t;

endpackage

[rtl/core/exact_drift_particle_map.sv]
// ---------------------------------------------------------------------------
// exact_drift_particle_map
// Exact symplectic drift of one particle per cycle, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   part_* carries one particle (positions, momenta, delta, bunch mark) per
//   valid/ready transfer; res_* returns the drifted particle in the same
//   order. cfg_wen/cfg_wdata write the drift length; write it only while
//   the pipeline is empty.
// Throughput: one particle per cycle while the skid register is not full.
// Depth: from the input transfer to res_valid the pipeline depth is set by
//   the bit-per-stage square root (WORD_BITS+FRAC_BITS stages) and the
//   bit-per-stage dividers (WORD_BITS stages), plus the multiplier and
//   output stages; words are Q8.24 by default.
// Reset: arst_n clears all valid bits and the drift length to zero.
// Stall: while res_ready is low the pipeline keeps moving until one more
//   result lands in a skid register; part_ready then drops until the
//   receiver takes a result. Nothing is lost or repeated.
// Nonpositive 1+delta or radicand: positions pass unchanged, invalid set.
// Position overflow: result saturates, invalid set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module exact_drift_particle_map (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  part_valid,
	output logic                                  part_ready,
	input  edpm_pkg::in_t                         part_data,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output edpm_pkg::out_t                        res_data,
	input  logic                                  cfg_wen,
	input  logic signed [edpm_pkg::WORD_BITS-1:0] cfg_wdata
);

	// local stage types
	typedef struct packed {
		edpm_pkg::pass_t                      p;
		logic [edpm_pkg::WORD_BITS-1:0]       e;
		logic [2*edpm_pkg::WORD_BITS-1:0]     pxl;
		logic [2*edpm_pkg::WORD_BITS-1:0]     pyl;
		logic [3*edpm_pkg::WORD_BITS-1:0]     plm;
		logic [2*edpm_pkg::WORD_BITS-1:0]     rad;
		logic [edpm_pkg::QW:0]                rem;
		logic [edpm_pkg::QW-1:0]              root;
	} sq_t;

	typedef struct packed {
		edpm_pkg::pass_t                                 p;
		logic [edpm_pkg::QW-1:0]                         q;
		logic [edpm_pkg::SW-1:0]                         sq;
		logic [3*edpm_pkg::WORD_BITS-1:0]                plm;
		logic                                            ovx;
		logic                                            ovy;
		logic [edpm_pkg::QW:0]                           rx;
		logic [edpm_pkg::QW:0]                           ry;
		logic [edpm_pkg::WORD_BITS-1:0]                  nxlo;
		logic [edpm_pkg::WORD_BITS-1:0]                  nylo;
		logic [edpm_pkg::QLO+edpm_pkg::SLO-1:0]          ll;
		logic [edpm_pkg::QLO+edpm_pkg::SHI-1:0]          lh;
		logic [edpm_pkg::QHI+edpm_pkg::SLO-1:0]          hl;
		logic [edpm_pkg::QHI+edpm_pkg::SHI-1:0]          hh;
		logic [edpm_pkg::DW-1:0]                         den;
	} md_t;

	typedef struct packed {
		edpm_pkg::pass_t                  p;
		logic [edpm_pkg::QW-1:0]          q;
		logic [edpm_pkg::DW-1:0]          den;
		logic                             ovx;
		logic                             ovy;
		logic                             ovz;
		logic [edpm_pkg::QW:0]            rx;
		logic [edpm_pkg::QW:0]            ry;
		logic [edpm_pkg::DW:0]            rz;
		logic [edpm_pkg::WORD_BITS-1:0]   nxlo;
		logic [edpm_pkg::WORD_BITS-1:0]   nylo;
		logic [edpm_pkg::WORD_BITS-1:0]   nzlo;
		logic [edpm_pkg::WORD_BITS-1:0]   qx;
		logic [edpm_pkg::WORD_BITS-1:0]   qy;
		logic [edpm_pkg::WORD_BITS-1:0]   qz;
	} dv_t;

	// magnitude of a two's complement word
	function automatic logic [edpm_pkg::WORD_BITS-1:0] mag_f(
		input logic [edpm_pkg::WORD_BITS-1:0] v
	);
		mag_f = v[edpm_pkg::WORD_BITS-1] ? ((~v) + edpm_pkg::WORD_BITS'(1)) : v;
	endfunction

	// saturating add of a signed word and a sign/magnitude step: {sat, value}
	function automatic logic [edpm_pkg::WORD_BITS:0] sadd_f(
		input logic [edpm_pkg::WORD_BITS-1:0] x,
		input logic                           neg,
		input logic [edpm_pkg::WORD_BITS-1:0] m
	);
		logic signed [edpm_pkg::WORD_BITS+1:0] xs;
		logic signed [edpm_pkg::WORD_BITS+1:0] ds;
		logic signed [edpm_pkg::WORD_BITS+1:0] sum;
		logic signed [edpm_pkg::WORD_BITS+1:0] lim_hi;
		logic signed [edpm_pkg::WORD_BITS+1:0] lim_lo;
		xs     = {{2{x[edpm_pkg::WORD_BITS-1]}}, x};
		ds     = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
		sum    = xs + ds;
		lim_hi = {3'b000, {(edpm_pkg::WORD_BITS-1){1'b1}}};
		lim_lo = {3'b111, {(edpm_pkg::WORD_BITS-1){1'b0}}};
		if (sum > lim_hi) begin
			sadd_f = {1'b1, 1'b0, {(edpm_pkg::WORD_BITS-1){1'b1}}};
		end else if (sum < lim_lo) begin
			sadd_f = {1'b1, 1'b1, {(edpm_pkg::WORD_BITS-1){1'b0}}};
		end else begin
			sadd_f = {1'b0, sum[edpm_pkg::WORD_BITS-1:0]};
		end
	endfunction

	// drift length register
	logic [edpm_pkg::WORD_BITS-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_wen) begin
			len_q <= cfg_wdata;
		end
	end

	// pipeline advance: held only while the skid register is full
	logic adv;
	logic skd_v_q;
	assign adv        = !skd_v_q;
	assign part_ready = adv;

	// ---------------- stage 1: magnitudes, 1+delta ----------------
	logic                            v_s1;
	edpm_pkg::pass_t                 p_s1;
	logic [edpm_pkg::WORD_BITS-1:0]  pxm_s1, pym_s1, e_s1, lm_s1;
	logic [edpm_pkg::WORD_BITS-1:0]  dm_c, e_c;
	logic                            bad_c;

	always_comb begin
		dm_c  = mag_f(part_data.delta_mom);
		e_c   = '0;
		bad_c = 1'b0;
		priority if (!part_data.delta_mom[edpm_pkg::WORD_BITS-1]) begin
			e_c = dm_c + edpm_pkg::ONE_W;
		end else if (dm_c < edpm_pkg::ONE_W) begin
			e_c = edpm_pkg::ONE_W - dm_c;
		end else begin
			bad_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= part_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.item <= part_data;
			p_s1.ln   <= len_q[edpm_pkg::WORD_BITS-1];
			p_s1.bad  <= bad_c;
			pxm_s1    <= mag_f(part_data.px_mom);
			pym_s1    <= mag_f(part_data.py_mom);
			e_s1      <= e_c;
			lm_s1     <= mag_f(len_q);
		end
	end

	// ---------------- stage 2: squares and momentum times length ----------------
	logic                              v_s2;
	edpm_pkg::pass_t                   p_s2;
	logic [2*edpm_pkg::WORD_BITS-1:0]  e2_s2, px2_s2, py2_s2, pxl_s2, pyl_s2;
	logic [edpm_pkg::WORD_BITS-1:0]    e_s2, lm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2   <= p_s1;
			e2_s2  <= e_s1 * e_s1;
			px2_s2 <= pxm_s1 * pxm_s1;
			py2_s2 <= pym_s1 * pym_s1;
			pxl_s2 <= pxm_s1 * lm_s1;
			pyl_s2 <= pym_s1 * lm_s1;
			e_s2   <= e_s1;
			lm_s2  <= lm_s1;
		end
	end

	// ---------------- stage 3: transverse sum and radicand ----------------
	logic                              v_s3;
	edpm_pkg::pass_t                   p_s3;
	logic [2*edpm_pkg::WORD_BITS-1:0]  p2_s3, r_s3, pxl_s3, pyl_s3;
	logic [edpm_pkg::WORD_BITS-1:0]    e_s3, lm_s3;
	logic [2*edpm_pkg::WORD_BITS-1:0]  p2_c;
	edpm_pkg::pass_t                   p3_c;

	assign p2_c = px2_s2 + py2_s2;

	// nonpositive radicand joins the nonphysical flag
	always_comb begin
		p3_c     = p_s2;
		p3_c.bad = p_s2.bad | (e2_s2 <= p2_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3      <= p3_c;
			p2_s3     <= p2_c;
			r_s3      <= e2_s2 - p2_c;
			pxl_s3    <= pxl_s2;
			pyl_s3    <= pyl_s2;
			e_s3      <= e_s2;
			lm_s3     <= lm_s2;
		end
	end

	// ---------------- stage 4: partial products of p2 * length ----------------
	logic                              v_s4;
	edpm_pkg::pass_t                   p_s4;
	logic [2*edpm_pkg::WORD_BITS-1:0]  pa_s4, pb_s4, r_s4, pxl_s4, pyl_s4;
	logic [edpm_pkg::WORD_BITS-1:0]    e_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4   <= p_s3;
			pa_s4  <= p2_s3[edpm_pkg::WORD_BITS-1:0] * lm_s3;
			pb_s4  <= p2_s3[2*edpm_pkg::WORD_BITS-1:edpm_pkg::WORD_BITS] * lm_s3;
			r_s4   <= r_s3;
			pxl_s4 <= pxl_s3;
			pyl_s4 <= pyl_s3;
			e_s4   <= e_s3;
		end
	end

	// ---------------- stage 5 and square root stages ----------------
	sq_t  sq_s  [0:edpm_pkg::QW];
	logic sqv_s [0:edpm_pkg::QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s[0] <= 1'b0;
		end else if (adv) begin
			sqv_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].p    <= p_s4;
			sq_s[0].e    <= e_s4;
			sq_s[0].pxl  <= pxl_s4;
			sq_s[0].pyl  <= pyl_s4;
			sq_s[0].plm  <= (3*edpm_pkg::WORD_BITS)'(pa_s4)
				+ ((3*edpm_pkg::WORD_BITS)'(pb_s4) << edpm_pkg::WORD_BITS);
			sq_s[0].rad  <= r_s4;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
		end
	end

	// one root bit per stage, radicand scaled by 2^(2*FRAC_BITS)
	for (genvar k = 0; k < edpm_pkg::QW; k++) begin : g_sqrt
		logic [2*edpm_pkg::QW-1:0] radx;
		logic [1:0]                dig;
		logic [edpm_pkg::QW+2:0]   pre;
		logic [edpm_pkg::QW+2:0]   trial;
		sq_t                       nxt;

		assign radx  = {sq_s[k].rad, {(2*edpm_pkg::FRAC_BITS){1'b0}}};
		assign dig   = radx[2*edpm_pkg::QW-1-2*k -: 2];
		assign pre   = {sq_s[k].rem, dig};
		assign trial = {1'b0, sq_s[k].root, 2'b01};

		always_comb begin
			nxt = sq_s[k];
			if (pre >= trial) begin
				nxt.rem  = (edpm_pkg::QW+1)'(pre - trial);
				nxt.root = {sq_s[k].root[edpm_pkg::QW-2:0], 1'b1};
			end else begin
				nxt.rem  = (edpm_pkg::QW+1)'(pre);
				nxt.root = {sq_s[k].root[edpm_pkg::QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k+1] <= 1'b0;
			end else if (adv) begin
				sqv_s[k+1] <= sqv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// ---------------- denominator stages ----------------
	md_t  md_s1, md_s2, md_s3;
	md_t  md1_c, md2_c, md3_c;
	logic mdv_s1, mdv_s2, mdv_s3;
	logic [edpm_pkg::NXW-1:0] nx_c, ny_c;
	logic [edpm_pkg::NXW-1:0] qsh_c;

	assign nx_c  = {sq_s[edpm_pkg::QW].pxl, {edpm_pkg::FRAC_BITS{1'b0}}};
	assign ny_c  = {sq_s[edpm_pkg::QW].pyl, {edpm_pkg::FRAC_BITS{1'b0}}};
	assign qsh_c = {sq_s[edpm_pkg::QW].root, {edpm_pkg::WORD_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdv_s1 <= 1'b0;
			mdv_s2 <= 1'b0;
			mdv_s3 <= 1'b0;
		end else if (adv) begin
			mdv_s1 <= sqv_s[edpm_pkg::QW];
			mdv_s2 <= mdv_s1;
			mdv_s3 <= mdv_s2;
		end
	end

	// pz + (1+delta), quotient overflow tests and first remainders for x/y
	always_comb begin
		md1_c      = '0;
		md1_c.p    = sq_s[edpm_pkg::QW].p;
		md1_c.q    = sq_s[edpm_pkg::QW].root;
		md1_c.sq   = edpm_pkg::SW'(sq_s[edpm_pkg::QW].root)
			+ (edpm_pkg::SW'(sq_s[edpm_pkg::QW].e) << edpm_pkg::FRAC_BITS);
		md1_c.plm  = sq_s[edpm_pkg::QW].plm;
		md1_c.ovx  = nx_c >= qsh_c;
		md1_c.ovy  = ny_c >= qsh_c;
		md1_c.rx   = (edpm_pkg::QW+1)'(nx_c >> edpm_pkg::WORD_BITS);
		md1_c.ry   = (edpm_pkg::QW+1)'(ny_c >> edpm_pkg::WORD_BITS);
		md1_c.nxlo = nx_c[edpm_pkg::WORD_BITS-1:0];
		md1_c.nylo = ny_c[edpm_pkg::WORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			md_s1 <= md1_c;
		end
	end

	// partial products of pz * (pz + 1 + delta)
	always_comb begin
		md2_c    = md_s1;
		md2_c.ll = (edpm_pkg::QLO+edpm_pkg::SLO)'(
			md_s1.q[edpm_pkg::QLO-1:0] * md_s1.sq[edpm_pkg::SLO-1:0]);
		md2_c.lh = (edpm_pkg::QLO+edpm_pkg::SHI)'(
			md_s1.q[edpm_pkg::QLO-1:0] * md_s1.sq[edpm_pkg::SW-1:edpm_pkg::SLO]);
		md2_c.hl = (edpm_pkg::QHI+edpm_pkg::SLO)'(
			md_s1.q[edpm_pkg::QW-1:edpm_pkg::QLO] * md_s1.sq[edpm_pkg::SLO-1:0]);
		md2_c.hh = (edpm_pkg::QHI+edpm_pkg::SHI)'(
			md_s1.q[edpm_pkg::QW-1:edpm_pkg::QLO]
			* md_s1.sq[edpm_pkg::SW-1:edpm_pkg::SLO]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			md_s2 <= md2_c;
		end
	end

	// partial product sum
	always_comb begin
		md3_c     = md_s2;
		md3_c.den = edpm_pkg::DW'(md_s2.ll)
			+ (edpm_pkg::DW'(md_s2.lh) << edpm_pkg::SLO)
			+ (edpm_pkg::DW'(md_s2.hl) << edpm_pkg::QLO)
			+ (edpm_pkg::DW'(md_s2.hh) << (edpm_pkg::QLO + edpm_pkg::SLO));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			md_s3 <= md3_c;
		end
	end

	// ---------------- divider stages ----------------
	dv_t  dv_s  [0:edpm_pkg::WORD_BITS];
	logic dvv_s [0:edpm_pkg::WORD_BITS];
	logic [edpm_pkg::NZW-1:0]   nz_c;
	logic [edpm_pkg::NZW:0]     dsh_c;

	assign nz_c  = {md_s3.plm, {(2*edpm_pkg::FRAC_BITS){1'b0}}};
	assign dsh_c = {md_s3.den, {edpm_pkg::WORD_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s[0] <= 1'b0;
		end else if (adv) begin
			dvv_s[0] <= mdv_s3;
		end
	end

	// z overflow test and first remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].p    <= md_s3.p;
			dv_s[0].q    <= md_s3.q;
			dv_s[0].den  <= md_s3.den;
			dv_s[0].ovx  <= md_s3.ovx;
			dv_s[0].ovy  <= md_s3.ovy;
			dv_s[0].ovz  <= {1'b0, nz_c} >= dsh_c;
			dv_s[0].rx   <= md_s3.rx;
			dv_s[0].ry   <= md_s3.ry;
			dv_s[0].rz   <= (edpm_pkg::DW+1)'(nz_c >> edpm_pkg::WORD_BITS);
			dv_s[0].nxlo <= md_s3.nxlo;
			dv_s[0].nylo <= md_s3.nylo;
			dv_s[0].nzlo <= nz_c[edpm_pkg::WORD_BITS-1:0];
			dv_s[0].qx   <= '0;
			dv_s[0].qy   <= '0;
			dv_s[0].qz   <= '0;
		end
	end

	// one quotient bit per stage for x, y and z
	for (genvar k = 0; k < edpm_pkg::WORD_BITS; k++) begin : g_div
		logic [edpm_pkg::QW:0] prex, prey, dq;
		logic [edpm_pkg::DW:0] prez, dd;
		dv_t                   nxt;

		assign dq   = {1'b0, dv_s[k].q};
		assign dd   = {1'b0, dv_s[k].den};
		assign prex = {dv_s[k].rx[edpm_pkg::QW-1:0], dv_s[k].nxlo[edpm_pkg::WORD_BITS-1]};
		assign prey = {dv_s[k].ry[edpm_pkg::QW-1:0], dv_s[k].nylo[edpm_pkg::WORD_BITS-1]};
		assign prez = {dv_s[k].rz[edpm_pkg::DW-1:0], dv_s[k].nzlo[edpm_pkg::WORD_BITS-1]};

		always_comb begin
			nxt      = dv_s[k];
			nxt.nxlo = {dv_s[k].nxlo[edpm_pkg::WORD_BITS-2:0], 1'b0};
			nxt.nylo = {dv_s[k].nylo[edpm_pkg::WORD_BITS-2:0], 1'b0};
			nxt.nzlo = {dv_s[k].nzlo[edpm_pkg::WORD_BITS-2:0], 1'b0};
			nxt.rx   = (prex >= dq) ? (prex - dq) : prex;
			nxt.ry   = (prey >= dq) ? (prey - dq) : prey;
			nxt.rz   = (prez >= dd) ? (prez - dd) : prez;
			nxt.qx   = {dv_s[k].qx[edpm_pkg::WORD_BITS-2:0], prex >= dq};
			nxt.qy   = {dv_s[k].qy[edpm_pkg::WORD_BITS-2:0], prey >= dq};
			nxt.qz   = {dv_s[k].qz[edpm_pkg::WORD_BITS-2:0], prez >= dd};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k+1] <= 1'b0;
			end else if (adv) begin
				dvv_s[k+1] <= dvv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// ---------------- final stage: clamp, saturating add ----------------
	dv_t                            dvf;
	logic [edpm_pkg::WORD_BITS-1:0] dxm_c, dym_c, dzm_c;
	logic [edpm_pkg::WORD_BITS:0]   sx_c, sy_c, sz_c;
	edpm_pkg::out_t                 res_c;
	edpm_pkg::out_t                 fin_s;
	logic                           finv_s;

	assign dvf = dv_s[edpm_pkg::WORD_BITS];

	always_comb begin
		dxm_c = dvf.ovx ? '1 : dvf.qx;
		dym_c = dvf.ovy ? '1 : dvf.qy;
		dzm_c = dvf.ovz ? '1 : dvf.qz;
		sx_c  = sadd_f(dvf.p.item.x_pos,
			dvf.p.item.px_mom[edpm_pkg::WORD_BITS-1] ^ dvf.p.ln, dxm_c);
		sy_c  = sadd_f(dvf.p.item.y_pos,
			dvf.p.item.py_mom[edpm_pkg::WORD_BITS-1] ^ dvf.p.ln, dym_c);
		sz_c  = sadd_f(dvf.p.item.z_pos, !dvf.p.ln, dzm_c);

		res_c.px_out    = dvf.p.item.px_mom;
		res_c.py_out    = dvf.p.item.py_mom;
		res_c.delta_out = dvf.p.item.delta_mom;
		res_c.last_out  = dvf.p.item.last_in;
		if (dvf.p.bad) begin
			res_c.x_new   = dvf.p.item.x_pos;
			res_c.y_new   = dvf.p.item.y_pos;
			res_c.z_new   = dvf.p.item.z_pos;
			res_c.invalid = 1'b1;
		end else begin
			res_c.x_new   = sx_c[edpm_pkg::WORD_BITS-1:0];
			res_c.y_new   = sy_c[edpm_pkg::WORD_BITS-1:0];
			res_c.z_new   = sz_c[edpm_pkg::WORD_BITS-1:0];
			res_c.invalid = sx_c[edpm_pkg::WORD_BITS] | sy_c[edpm_pkg::WORD_BITS]
				| sz_c[edpm_pkg::WORD_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finv_s <= 1'b0;
		end else if (adv) begin
			finv_s <= dvv_s[edpm_pkg::WORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s <= res_c;
		end
	end

	// ---------------- output register with skid ----------------
	edpm_pkg::out_t out_q, skd_q;
	logic           out_v_q;
	logic           pop, push;

	assign pop  = out_v_q && res_ready;
	assign push = adv && finv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skd_v_q <= 1'b0;
		end else begin
			priority if (pop && skd_v_q) begin
				skd_v_q <= 1'b0;
			end else if (pop) begin
				out_v_q <= push;
			end else if (push && out_v_q) begin
				skd_v_q <= 1'b1;
			end else if (push) begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && skd_v_q) begin
			out_q <= skd_q;
		end else if (push && (pop || !out_v_q)) begin
			out_q <= fin_s;
		end else if (push) begin
			skd_q <= fin_s;
		end
	end

	assign res_valid = out_v_q;
	assign res_data  = out_q;

endmodule

[rtl/core/edpm_checker.sv]
// ---------------------------------------------------------------------------
// edpm_checker
// Port-level checks of the exact drift particle map, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "exact_drift_particle_map_assert.svh"

module edpm_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  part_valid,
	input logic                                  part_ready,
	input edpm_pkg::in_t                         part_data,
	input logic                                  res_valid,
	input logic                                  res_ready,
	input edpm_pkg::out_t                        res_data,
	input logic                                  cfg_wen,
	input logic signed [edpm_pkg::WORD_BITS-1:0] cfg_wdata
);

	// result carries 1+delta at or below zero
	logic nonphys;
	assign nonphys = res_valid
		&& ($signed(res_data.delta_out) <= -$signed(edpm_pkg::ONE_W));

	// a stalled result stays offered
	`EDPM_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

	// a stalled result keeps its payload
	`EDPM_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(res_data))

	// input backpressure only while a result is waiting
	`EDPM_ASSERT_IMP(a_ready_low, !part_ready, res_valid)

	// nonpositive 1+delta always flags the particle
	`EDPM_ASSERT_IMP(a_nonphys, nonphys, res_data.invalid)

endmodule

bind exact_drift_particle_map edpm_checker u_edpm_checker (.*);
